[rtl/des_pkg.sv]
// Package for the dual encoder speed estimator: widths, reset values,
// microcode encoding and the control store shared by the core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

    // Fixed field widths.
    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 32;
    localparam int ALPHA_W     = 17;
    localparam int MIN_W       = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 1;
    localparam int LANES       = 2;

    // Default angle width.
    localparam int ANGLE_BITS_DEF = 14;

    // Speed scale before adjustment for angle width: 60 s * 1e6 us * 256 / 2^16.
    localparam int SCALE_BASE = 234375;

    // The scaled numerator magnitude stays below 2^33.
    localparam int NUM_W     = 33;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Filter arithmetic: 32-bit speed times 18-bit signed weight.
    localparam int PROD_W = SPEED_W + ALPHA_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH_W   = SUM_W - 16;

    localparam logic [ALPHA_W-1:0] ONE_Q16       = ALPHA_W'(65536);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET   = ALPHA_W'(6554);
    localparam logic [MIN_W-1:0]   MIN_INT_RESET = MIN_W'(200);

    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA        = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL = CFG_INDEX_W'(1);

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 32'sh8000_0000;

    // Microcode.
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_LOAD,
        OP_DIFF,
        OP_SCALE,
        OP_DIV,
        OP_SAT,
        OP_MULA,
        OP_MULB,
        OP_SUM,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_IN_WAIT,
        COND_TOO_SOON,
        COND_DIV_LOOP,
        COND_OUT_WAIT
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } cw_t;

    localparam logic [PC_W-1:0] PC_LOAD  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CHECK = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SCALE = PC_W'(2);
    localparam logic [PC_W-1:0] PC_DIV   = PC_W'(3);
    localparam logic [PC_W-1:0] PC_SAT   = PC_W'(4);
    localparam logic [PC_W-1:0] PC_MULA  = PC_W'(5);
    localparam logic [PC_W-1:0] PC_MULB  = PC_W'(6);
    localparam logic [PC_W-1:0] PC_SUM   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(8);

    // Control store: one word per step.
    function automatic cw_t ucode(input logic [PC_W-1:0] pc);
        cw_t w;
        w = '{op: OP_LOAD, cond: COND_IN_WAIT, target: PC_LOAD};
        unique case (pc)
            PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_IN_WAIT,  target: PC_LOAD};
            PC_CHECK: w = '{op: OP_DIFF,  cond: COND_TOO_SOON, target: PC_LOAD};
            PC_SCALE: w = '{op: OP_SCALE, cond: COND_NEXT,     target: PC_LOAD};
            PC_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_LOOP, target: PC_LOAD};
            PC_SAT:   w = '{op: OP_SAT,   cond: COND_NEXT,     target: PC_LOAD};
            PC_MULA:  w = '{op: OP_MULA,  cond: COND_NEXT,     target: PC_LOAD};
            PC_MULB:  w = '{op: OP_MULB,  cond: COND_NEXT,     target: PC_LOAD};
            PC_SUM:   w = '{op: OP_SUM,   cond: COND_NEXT,     target: PC_LOAD};
            PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_WAIT, target: PC_LOAD};
            default:  w = '{op: OP_LOAD,  cond: COND_IN_WAIT,  target: PC_LOAD};
        endcase
        return w;
    endfunction

    // Clamp a shifted filter sum into the signed 32-bit speed range.
    function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SH_W-1:0] v);
        logic signed [SPEED_W-1:0] r;
        if (v > SH_W'(SPEED_MAX)) begin
            r = SPEED_MAX;
        end else if (v < SH_W'(SPEED_MIN)) begin
            r = SPEED_MIN;
        end else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/dual_encoder_speed_ema_core.sv]
// Dual absolute encoder speed estimator with exponential smoothing.
// Depends on des_pkg (widths, microcode store, saturation helper).
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   s_tdata: now_us, angle_left, angle_right
// m_*       out        m_tvalid / m_tready   m_tdata: rpm_left, rpm_right, angles
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Flow: an accepted sample's result word is made by the check, scale, divide,
// saturate, multiply, sum and emit steps, and the next sample can be taken once
// the sequencer is back at its load step; the 33-step restoring divider, one per
// channel in parallel, takes most of that time. A too-soon sample is dropped.
// Reset: all stored state clears to zero, alpha to 6554, the interval to 200.
// Stalls: a finished word waits in the output register while the next sample
// is accepted; the sequencer only holds on its last step if that word is
// still waiting when the next one is ready.
`timescale 1ns / 1ps
`default_nettype none

module dual_encoder_speed_ema_core #(
    parameter int ANGLE_BITS = des_pkg::ANGLE_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,

    // Bits from lowest: now_us[31:0], angle_left, angle_right, zero fill.
    input  wire logic [((32 + 2*ANGLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  wire logic s_tvalid,
    output logic      s_tready,

    // Bits from lowest: rpm_left[31:0], rpm_right[31:0], angle_left_out,
    // angle_right_out, zero fill.
    output logic [((64 + 2*ANGLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [des_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [des_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AB     = ANGLE_BITS;
    localparam int DW     = AB + 2;
    localparam int SC_W   = 34 - AB;
    localparam int OUT_DW = ((64 + 2*AB + 7) / 8) * 8;
    localparam int SW     = des_pkg::SPEED_W;
    localparam int NW     = des_pkg::NUM_W;
    localparam int PW     = des_pkg::PROD_W;

    localparam logic [SC_W-1:0] SCALE =
        SC_W'(des_pkg::SCALE_BASE * (2 ** (16 - ANGLE_BITS)));
    localparam logic signed [DW-1:0] HALF_TURN = DW'(2 ** (ANGLE_BITS - 1));
    localparam logic signed [DW-1:0] FULL_TURN = DW'(2 ** ANGLE_BITS);

    // Sequencer.
    logic [des_pkg::PC_W-1:0] pc_reg, pc_next;
    des_pkg::cw_t cw;

    // Configuration.
    logic [des_pkg::ALPHA_W-1:0] alpha_reg;
    logic [des_pkg::MIN_W-1:0]   min_int_reg;

    // Stored sample state.
    logic [des_pkg::TIME_W-1:0] last_time_reg;
    logic [AB-1:0]              prev_reg  [des_pkg::LANES];
    logic signed [SW-1:0]       speed_reg [des_pkg::LANES];

    // Working registers.
    logic [des_pkg::TIME_W-1:0] now_reg, dt_reg;
    logic [AB-1:0]              ang_reg  [des_pkg::LANES];
    logic                       neg_reg  [des_pkg::LANES];
    logic [AB-1:0]              mag_reg  [des_pkg::LANES];
    logic [NW-1:0]              q_reg    [des_pkg::LANES];
    logic [31:0]                rem_reg  [des_pkg::LANES];
    logic signed [SW-1:0]       inst_reg [des_pkg::LANES];
    logic signed [PW-1:0]       prod_reg [des_pkg::LANES];
    logic signed [PW-1:0]       acc_reg  [des_pkg::LANES];
    logic [des_pkg::CNT_W-1:0]  div_cnt_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [OUT_DW-1:0]          out_data_reg, out_data_next;

    // Next values of the lane registers.
    logic                       neg_next  [des_pkg::LANES];
    logic [AB-1:0]              mag_next  [des_pkg::LANES];
    logic [NW-1:0]              q_next    [des_pkg::LANES];
    logic [31:0]                rem_next  [des_pkg::LANES];
    logic signed [SW-1:0]       inst_next [des_pkg::LANES];
    logic signed [PW-1:0]       prod_next [des_pkg::LANES];
    logic signed [SW-1:0]       speed_next [des_pkg::LANES];

    logic [AB-1:0]              in_angle [des_pkg::LANES];
    logic                       s_fire;
    logic                       out_busy;
    logic                       emit_fire;
    logic                       too_soon;
    logic                       dt_zero;
    logic [des_pkg::ALPHA_W-1:0] a_eff, b_eff;

    assign cw        = des_pkg::ucode(pc_reg);
    assign s_tready  = (pc_reg == des_pkg::PC_LOAD);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_busy  = out_valid_reg && !m_tready;
    assign emit_fire = (cw.op == des_pkg::OP_EMIT) && !out_busy;
    assign too_soon  = dt_reg < {{(des_pkg::TIME_W - des_pkg::MIN_W){1'b0}}, min_int_reg};
    assign dt_zero   = (dt_reg == '0);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign in_angle[0] = s_tdata[32 +: AB];
    assign in_angle[1] = s_tdata[32 + AB +: AB];

    // Alpha above one acts as one.
    assign a_eff = (alpha_reg > des_pkg::ONE_Q16) ? des_pkg::ONE_Q16 : alpha_reg;
    assign b_eff = des_pkg::ONE_Q16 - a_eff;

    // Next step of the program.
    always_comb
    begin
        pc_next = pc_reg + des_pkg::PC_W'(1);
        unique case (cw.cond)
            des_pkg::COND_NEXT:     pc_next = pc_reg + des_pkg::PC_W'(1);
            des_pkg::COND_IN_WAIT:  pc_next = s_fire ? pc_reg + des_pkg::PC_W'(1) : pc_reg;
            des_pkg::COND_TOO_SOON: pc_next = too_soon ? cw.target
                                                       : pc_reg + des_pkg::PC_W'(1);
            des_pkg::COND_DIV_LOOP: pc_next = (div_cnt_reg != des_pkg::CNT_W'(1))
                                              ? pc_reg : pc_reg + des_pkg::PC_W'(1);
            des_pkg::COND_OUT_WAIT: pc_next = out_busy ? pc_reg : cw.target;
            default:                pc_next = des_pkg::PC_LOAD;
        endcase
    end

    // Lane datapath: both channels run the same step at once.
    always_comb
    begin
        logic signed [DW-1:0]     diff;
        logic signed [DW-1:0]     wrapped;
        logic [AB+SC_W-1:0]       scaled;
        logic [NW-1:0]            rem_sh;
        logic                     ge;
        logic [NW-1:0]            q_neg;
        logic signed [SW-1:0]     mul_x;
        logic [des_pkg::ALPHA_W-1:0] mul_y;
        logic signed [des_pkg::SUM_W-1:0] sum;
        for (int i = 0; i < des_pkg::LANES; i++)
        begin
            diff    = $signed({2'b00, ang_reg[i]}) - $signed({2'b00, prev_reg[i]});
            wrapped = diff;
            if (diff > HALF_TURN) begin
                wrapped = diff - FULL_TURN;
            end else if (diff < -HALF_TURN) begin
                wrapped = diff + FULL_TURN;
            end
            neg_next[i] = wrapped[DW-1];
            mag_next[i] = wrapped[DW-1] ? AB'(-wrapped) : wrapped[AB-1:0];

            scaled = {{SC_W{1'b0}}, mag_reg[i]} * {{AB{1'b0}}, SCALE};

            // One restoring division step.
            rem_sh = {rem_reg[i], q_reg[i][NW-1]};
            ge     = rem_sh >= {1'b0, dt_reg};

            q_neg  = NW'(0) - q_reg[i];

            mul_x = (cw.op == des_pkg::OP_MULA) ? inst_reg[i] : speed_reg[i];
            mul_y = (cw.op == des_pkg::OP_MULA) ? a_eff : b_eff;
            prod_next[i] = PW'(mul_x) * PW'($signed({1'b0, mul_y}));

            sum = des_pkg::SUM_W'(acc_reg[i]) + des_pkg::SUM_W'(prod_reg[i]);
            speed_next[i] = des_pkg::sat_speed(des_pkg::SH_W'(sum >>> 16));

            q_next[i]   = q_reg[i];
            rem_next[i] = rem_reg[i];
            case (cw.op)
                des_pkg::OP_SCALE:
                begin
                    q_next[i]   = scaled[NW-1:0];
                    rem_next[i] = '0;
                end
                des_pkg::OP_DIV:
                begin
                    q_next[i]   = {q_reg[i][NW-2:0], ge};
                    rem_next[i] = ge ? 32'(rem_sh - {1'b0, dt_reg}) : rem_sh[31:0];
                end
                default:
                begin
                    q_next[i]   = q_reg[i];
                    rem_next[i] = rem_reg[i];
                end
            endcase

            // Truncated quotient with sign, clamped; a zero interval gives
            // the signed extreme or zero.
            if (dt_zero) begin
                if (mag_reg[i] == '0) begin
                    inst_next[i] = '0;
                end else begin
                    inst_next[i] = neg_reg[i] ? des_pkg::SPEED_MIN : des_pkg::SPEED_MAX;
                end
            end else if (!neg_reg[i]) begin
                inst_next[i] = (q_reg[i] > NW'(33'h0_7FFF_FFFF)) ? des_pkg::SPEED_MAX
                                                                 : q_reg[i][SW-1:0];
            end else begin
                inst_next[i] = (q_reg[i] > NW'(33'h0_8000_0000)) ? des_pkg::SPEED_MIN
                                                                 : q_neg[SW-1:0];
            end
        end
    end

    // Result word and its valid flag.
    always_comb
    begin
        out_data_next = '0;
        out_data_next[0 +: SW]            = speed_reg[0];
        out_data_next[SW +: SW]           = speed_reg[1];
        out_data_next[2*SW +: AB]         = ang_reg[0];
        out_data_next[2*SW + AB +: AB]    = ang_reg[1];
        if (emit_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and stored state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg        <= des_pkg::PC_LOAD;
            out_valid_reg <= 1'b0;
            alpha_reg     <= des_pkg::ALPHA_RESET;
            min_int_reg   <= des_pkg::MIN_INT_RESET;
            last_time_reg <= '0;
            div_cnt_reg   <= '0;
            for (int i = 0; i < des_pkg::LANES; i++)
            begin
                prev_reg[i]  <= '0;
                speed_reg[i] <= '0;
            end
        end else begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    des_pkg::REG_ALPHA:
                        alpha_reg <= cfg_data[des_pkg::ALPHA_W-1:0];
                    des_pkg::REG_MIN_INTERVAL:
                        min_int_reg <= cfg_data[des_pkg::MIN_W-1:0];
                    default:
                        alpha_reg <= alpha_reg;
                endcase
            end
            if (cw.op == des_pkg::OP_SCALE) begin
                div_cnt_reg <= des_pkg::CNT_W'(des_pkg::DIV_STEPS);
            end else if (cw.op == des_pkg::OP_DIV) begin
                div_cnt_reg <= div_cnt_reg - des_pkg::CNT_W'(1);
            end
            if (emit_fire) begin
                last_time_reg <= now_reg;
            end
            for (int i = 0; i < des_pkg::LANES; i++)
            begin
                if (cw.op == des_pkg::OP_SUM) begin
                    speed_reg[i] <= speed_next[i];
                end
                if (emit_fire) begin
                    prev_reg[i] <= ang_reg[i];
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_fire) begin
            now_reg <= s_tdata[31:0];
            dt_reg  <= s_tdata[31:0] - last_time_reg;
        end
        if (emit_fire) begin
            out_data_reg <= out_data_next;
        end
        for (int i = 0; i < des_pkg::LANES; i++)
        begin
            if (s_fire) begin
                ang_reg[i] <= in_angle[i];
            end
            if (cw.op == des_pkg::OP_DIFF) begin
                neg_reg[i] <= neg_next[i];
                mag_reg[i] <= mag_next[i];
            end
            q_reg[i]   <= q_next[i];
            rem_reg[i] <= rem_next[i];
            if (cw.op == des_pkg::OP_SAT) begin
                inst_reg[i] <= inst_next[i];
            end
            if (cw.op == des_pkg::OP_MULA || cw.op == des_pkg::OP_MULB) begin
                prod_reg[i] <= prod_next[i];
            end
            if (cw.op == des_pkg::OP_MULB) begin
                acc_reg[i] <= prod_reg[i] + PW'(32768);
            end
        end
    end

`ifndef SYNTHESIS
    // After taking a sample the sequencer is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("input accepted twice in a row");

    // The divider loop never runs with an exhausted step count.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == des_pkg::OP_DIV) |-> (div_cnt_reg != '0))
        else $error("divider step count exhausted");

    // A result appears only from the emit step.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pc_reg == des_pkg::PC_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule

`default_nettype wire
